### rtl/ptpt_pkg.sv
// Shared constants, codes and types of the point-in-polygon test unit.
package ptpt_pkg;

  // Default sizes
  localparam int DEF_MAX_VERTICES = 16;
  localparam int DEF_COORD_WIDTH  = 24;

  // Smallest polygon that a vertex_count write may select
  localparam int MIN_VERTICES = 3;

  // APB data width
  localparam int APB_DW = 32;

  // Operation codes of an input word
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_TEST  = 1'b1;

  // Register index decoded from paddr
  localparam logic REG_VERTEX_COUNT = 1'b0;

  // Status handed from the edge unit to the sequencer
  typedef struct packed {
    logic busy;   // an edge is still in flight
    logic hit;    // an edge straddling the point leaves the pipe
    logic below;  // that edge passes below the point
  } edge_res_t;

endpackage

### rtl/ptpt_cell.sv
// One vertex cell of the rotating polygon ring.
module ptpt_cell
  import ptpt_pkg::*;
#(
  parameter int COORD_WIDTH = DEF_COORD_WIDTH
) (
  input  logic                          clk,
  input  logic                          wr_en,
  input  logic signed [COORD_WIDTH-1:0] wr_u,
  input  logic signed [COORD_WIDTH-1:0] wr_v,
  input  logic                          sh_en,
  input  logic signed [COORD_WIDTH-1:0] sh_u,
  input  logic signed [COORD_WIDTH-1:0] sh_v,
  output logic signed [COORD_WIDTH-1:0] vert_u,
  output logic signed [COORD_WIDTH-1:0] vert_v
);

  logic signed [COORD_WIDTH-1:0] u_r, u_nxt;
  logic signed [COORD_WIDTH-1:0] v_r, v_nxt;

  // Take a written vertex, or the neighbour's vertex while the ring turns
  always_comb begin
    u_nxt = u_r;
    v_nxt = v_r;
    if (wr_en) begin
      u_nxt = wr_u;
      v_nxt = wr_v;
    end else if (sh_en) begin
      u_nxt = sh_u;
      v_nxt = sh_v;
    end
  end

  always_ff @(posedge clk) begin
    u_r <= u_nxt;
    v_r <= v_nxt;
  end

  assign vert_u = u_r;
  assign vert_v = v_r;

endmodule

### rtl/ptpt_edge_unit.sv
// Shared edge unit: straddle check, exact cross-multiply and side compare.
module ptpt_edge_unit
  import ptpt_pkg::*;
#(
  parameter int COORD_WIDTH = DEF_COORD_WIDTH
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          issue,
  input  logic signed [COORD_WIDTH-1:0] pt_u,
  input  logic signed [COORD_WIDTH-1:0] pt_v,
  input  logic signed [COORD_WIDTH-1:0] u1,
  input  logic signed [COORD_WIDTH-1:0] v1,
  input  logic signed [COORD_WIDTH-1:0] u2,
  input  logic signed [COORD_WIDTH-1:0] v2,
  output edge_res_t                     res
);

  localparam int DW = COORD_WIDTH + 1;
  localparam int PW = 2 * DW;

  // Stage A: differences and straddle flag
  logic                 a_vld_r, a_vld_nxt;
  logic                 a_str_r, a_str_nxt;
  logic                 a_neg_r, a_neg_nxt;
  logic signed [DW-1:0] a_du_r, a_du_nxt;
  logic signed [DW-1:0] a_dv_r, a_dv_nxt;
  logic signed [DW-1:0] a_pdu_r, a_pdu_nxt;
  logic signed [DW-1:0] a_pdv_r, a_pdv_nxt;

  // Stage B: the two cross products
  logic                 b_vld_r, b_vld_nxt;
  logic                 b_str_r, b_str_nxt;
  logic                 b_neg_r, b_neg_nxt;
  logic signed [PW-1:0] b_l_r, b_l_nxt;
  logic signed [PW-1:0] b_r_r, b_r_nxt;

  // Form edge and point differences, one extra bit so nothing wraps
  always_comb begin
    a_vld_nxt = issue;
    a_str_nxt = (pt_u < u1) != (pt_u < u2);
    a_du_nxt  = $signed({u2[COORD_WIDTH-1], u2}) - $signed({u1[COORD_WIDTH-1], u1});
    a_dv_nxt  = $signed({v2[COORD_WIDTH-1], v2}) - $signed({v1[COORD_WIDTH-1], v1});
    a_pdu_nxt = $signed({pt_u[COORD_WIDTH-1], pt_u}) - $signed({u1[COORD_WIDTH-1], u1});
    a_pdv_nxt = $signed({pt_v[COORD_WIDTH-1], pt_v}) - $signed({v1[COORD_WIDTH-1], v1});
    a_neg_nxt = a_du_nxt[DW-1];
  end

  // Multiply: L = dv * (pu - u1), R = (pv - v1) * du
  always_comb begin
    b_vld_nxt = a_vld_r;
    b_str_nxt = a_str_r;
    b_neg_nxt = a_neg_r;
    b_l_nxt   = PW'(a_dv_r) * PW'(a_pdu_r);
    b_r_nxt   = PW'(a_pdv_r) * PW'(a_du_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
      b_vld_r <= 1'b0;
    end else begin
      a_vld_r <= a_vld_nxt;
      b_vld_r <= b_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    a_str_r <= a_str_nxt;
    a_neg_r <= a_neg_nxt;
    a_du_r  <= a_du_nxt;
    a_dv_r  <= a_dv_nxt;
    a_pdu_r <= a_pdu_nxt;
    a_pdv_r <= a_pdv_nxt;
    b_str_r <= b_str_nxt;
    b_neg_r <= b_neg_nxt;
    b_l_r   <= b_l_nxt;
    b_r_r   <= b_r_nxt;
  end

  // Decide the side; a point on the edge line counts as not below
  always_comb begin
    res.busy  = a_vld_r | b_vld_r;
    res.hit   = b_vld_r & b_str_r;
    res.below = b_neg_r ? (b_r_r < b_l_r) : (b_l_r < b_r_r);
  end

endmodule

### rtl/point_in_polygon_test_unit.sv
// Top level of the point-in-polygon test unit: vertex ring, sequencer, APB register.
//
// Usage:
//   Input channel (in_valid/in_ready) carries one word per operation. A write
//   word (in_operation = 0) stores (in_coord_u, in_coord_v) in vertex slot
//   in_vertex_index and gives no result. A test word (in_operation = 1)
//   checks the point (in_coord_u, in_coord_v) against the closed polygon of
//   vertex_count vertices and gives one result word on out_valid/out_ready.
//   Register vertex_count sits at byte address 0 of the APB port, is clamped
//   to 3..MAX_VERTICES on write, and must only be written while idle.
//   Timing: a write word is stored and the unit stays ready. A test word turns
//   the vertex ring once, one edge per cycle through a single shared
//   cross-multiply unit; each edge passes stage A and stage B of the edge
//   unit and the count update, then the output register raises out_valid,
//   and in_ready returns in the same cycle as out_valid, for the next word.
//   A stalled receiver holds the result in the output register; further
//   write words are still taken, a new test runs but waits to deliver.
//   Reset clears the sequencer and sets vertex_count to 3; vertex slots are
//   undefined until written.
module point_in_polygon_test_unit
  import ptpt_pkg::*;
#(
  parameter int MAX_VERTICES = DEF_MAX_VERTICES,
  parameter int COORD_WIDTH  = DEF_COORD_WIDTH
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // Input channel
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              in_operation,
  input  logic [$clog2(MAX_VERTICES)-1:0]   in_vertex_index,
  input  logic signed [COORD_WIDTH-1:0]     in_coord_u,
  input  logic signed [COORD_WIDTH-1:0]     in_coord_v,
  // Result channel
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic                              out_inside_res,
  // APB register port
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [2:0]                        paddr,
  input  logic [APB_DW-1:0]                 pwdata,
  output logic [APB_DW-1:0]                 prdata,
  output logic                              pready
);

  localparam int IDX_W = $clog2(MAX_VERTICES);
  localparam int CNT_W = $clog2(MAX_VERTICES + 1);
  localparam int UD_W  = CNT_W + 1;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_RUN   = 3'b010,
    ST_DRAIN = 3'b100
  } state_t;

  state_t                        state_r, state_nxt;
  logic [CNT_W-1:0]              n_r, n_nxt;
  logic [CNT_W-1:0]              cnt_r, cnt_nxt;
  logic [CNT_W-1:0]              found_r, found_nxt;
  logic signed [UD_W-1:0]        updown_r, updown_nxt;
  logic signed [COORD_WIDTH-1:0] pu_r, pu_nxt;
  logic signed [COORD_WIDTH-1:0] pv_r, pv_nxt;
  logic                          out_valid_r, out_valid_nxt;
  logic                          out_inside_r, out_inside_nxt;

  logic                          in_fire;
  logic                          wr_fire;
  logic                          test_fire;
  logic                          rotate;
  logic                          cfg_wr;
  logic [CNT_W-1:0]              cfg_val;
  logic signed [UD_W-1:0]        ud_abs;
  edge_res_t                     eres;

  logic signed [COORD_WIDTH-1:0] cell_u [MAX_VERTICES];
  logic signed [COORD_WIDTH-1:0] cell_v [MAX_VERTICES];

  assign in_ready  = (state_r == ST_IDLE);
  assign in_fire   = in_valid & in_ready;
  assign wr_fire   = in_fire & (in_operation == OP_WRITE);
  assign test_fire = in_fire & (in_operation == OP_TEST);
  assign rotate    = (state_r == ST_RUN);

  // Vertex ring: slots below vertex_count turn by one each run cycle
  for (genvar k = 0; k < MAX_VERTICES; k++) begin : g_cell
    logic                          sh_en;
    logic signed [COORD_WIDTH-1:0] sh_u;
    logic signed [COORD_WIDTH-1:0] sh_v;

    if (k == MAX_VERTICES - 1) begin : g_last
      assign sh_u = cell_u[0];
      assign sh_v = cell_v[0];
    end else begin : g_mid
      assign sh_u = (CNT_W'(k + 1) < n_r) ? cell_u[k+1] : cell_u[0];
      assign sh_v = (CNT_W'(k + 1) < n_r) ? cell_v[k+1] : cell_v[0];
    end
    assign sh_en = rotate & (CNT_W'(k) < n_r);

    ptpt_cell #(
      .COORD_WIDTH (COORD_WIDTH)
    ) u_cell (
      .clk    (clk),
      .wr_en  (wr_fire & (in_vertex_index == IDX_W'(k))),
      .wr_u   (in_coord_u),
      .wr_v   (in_coord_v),
      .sh_en  (sh_en),
      .sh_u   (sh_u),
      .sh_v   (sh_v),
      .vert_u (cell_u[k]),
      .vert_v (cell_v[k])
    );
  end

  // Edge unit sees the ring head and its successor
  ptpt_edge_unit #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_edge (
    .clk   (clk),
    .rst_n (rst_n),
    .issue (rotate),
    .pt_u  (pu_r),
    .pt_v  (pv_r),
    .u1    (cell_u[0]),
    .v1    (cell_v[0]),
    .u2    (cell_u[1]),
    .v2    (cell_v[1]),
    .res   (eres)
  );

  // APB register: clamp vertex_count into range on write
  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite & pready & (paddr[2] == REG_VERTEX_COUNT);
  assign cfg_val = pwdata[CNT_W-1:0];
  assign prdata  = (paddr[2] == REG_VERTEX_COUNT) ? APB_DW'(n_r) : '0;

  always_comb begin
    n_nxt = n_r;
    if (cfg_wr) begin
      if (cfg_val < CNT_W'(MIN_VERTICES)) begin
        n_nxt = CNT_W'(MIN_VERTICES);
      end else if (cfg_val > CNT_W'(MAX_VERTICES)) begin
        n_nxt = CNT_W'(MAX_VERTICES);
      end else begin
        n_nxt = cfg_val;
      end
    end
  end

  // Magnitude of the up-down count for the final parity
  assign ud_abs = updown_r[UD_W-1] ? -updown_r : updown_r;

  // Sequencer, accumulators and output register
  always_comb begin
    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    found_nxt      = found_r;
    updown_nxt     = updown_r;
    pu_nxt         = pu_r;
    pv_nxt         = pv_r;
    out_valid_nxt  = out_valid_r;
    out_inside_nxt = out_inside_r;

    // drop the delivered word
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    // count straddling edges as they leave the edge unit
    if (eres.hit) begin
      found_nxt  = found_r + CNT_W'(1);
      updown_nxt = eres.below ? updown_r + UD_W'(1) : updown_r - UD_W'(1);
    end

    unique case (state_r)
      ST_IDLE: begin
        if (test_fire) begin
          pu_nxt     = in_coord_u;
          pv_nxt     = in_coord_v;
          cnt_nxt    = '0;
          found_nxt  = '0;
          updown_nxt = '0;
          state_nxt  = ST_RUN;
        end
      end
      ST_RUN: begin
        cnt_nxt = cnt_r + CNT_W'(1);
        if (cnt_r == n_r - CNT_W'(1)) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!eres.busy && (!out_valid_r || out_ready)) begin
          out_valid_nxt  = 1'b1;
          out_inside_nxt = found_r[1] ^ ud_abs[1];
          state_nxt      = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      n_r         <= CNT_W'(MIN_VERTICES);
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      n_r         <= n_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r        <= cnt_nxt;
    found_r      <= found_nxt;
    updown_r     <= updown_nxt;
    pu_r         <= pu_nxt;
    pv_r         <= pv_nxt;
    out_inside_r <= out_inside_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_inside_res = out_inside_r;

endmodule
